@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define MQ_ASSERT_RAW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/mq_pkg.sv @@
// Types and constants for the matrix to quaternion pipeline.
package mq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FIELD_W       = 20;
    localparam int TOL_W         = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    // Quotient bits kept by the divider and root steps that consume them.
    localparam int QW         = 40;
    localparam int ROOT_STEPS = 20;
    // Width of a squared difference (magnitude up to 2^20).
    localparam int SQ_W       = 41;
    // Lane registers: setup, divide steps, root steps, encode.
    localparam int LANE_LAT   = 2 + QW + ROOT_STEPS;

    localparam logic [FIELD_W-1:0] POS_MAX = 20'h7FFFF;
    localparam logic [FIELD_W-1:0] NEG_MIN = 20'h80000;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    // Output component slots.
    localparam int P_X = 0;
    localparam int P_Y = 1;
    localparam int P_Z = 2;
    localparam int P_W = 3;

    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [1:0] branch;
    } side_t;

    // Divisor width: holds trace + one for any binary point.
    function automatic int tw_of(input int frac);
        return ((frac > 21) ? frac : 21) + 2;
    endfunction

endpackage

@@ sv/mq_front.sv @@
// Front stages: zero-row test, branch pick, lane operands and squares.
module mq_front #(
    parameter int FRAC_BITS = mq_pkg::FRAC_BITS_DEF,
    parameter int TW        = mq_pkg::tw_of(mq_pkg::FRAC_BITS_DEF)
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic [8:0][mq_pkg::FIELD_W-1:0]        mat,
    input  logic [mq_pkg::TOL_W-1:0]               tol,
    output mq_pkg::side_t                          side_out,
    output logic [3:0][mq_pkg::SQ_W-1:0]           sq_out,
    output logic [3:0][TW-1:0]                     div_out,
    output logic [3:0]                             neg_out
);
    import mq_pkg::*;

    localparam int EW = TW + 1;
    localparam logic signed [EW-1:0] ONE = EW'(1) <<< FRAC_BITS;

    // ---- stage 1 ----
    logic [2:0]  row_small;
    logic signed [21:0] tr_w;
    logic [1:0]  br_w;
    logic [1:0]  pick_w;

    always_comb begin
        logic [20:0] mg;
        for (int r = 0; r < 3; r++) begin
            row_small[r] = 1'b1;
            for (int c = 0; c < 3; c++) begin
                mg = mat[r*3+c][FIELD_W-1] ? (21'd0 - {1'b1, mat[r*3+c]})
                                           : {1'b0, mat[r*3+c]};
                if (mg > {5'd0, tol})
                    row_small[r] = 1'b0;
            end
        end
    end

    assign tr_w = 22'(signed'(mat[0])) + 22'(signed'(mat[4])) + 22'(signed'(mat[8]));

    always_comb begin
        pick_w = BR_X;
        if (signed'(mat[4]) > signed'(mat[0]))
            pick_w = BR_Y;
        priority if (pick_w == BR_Y) begin
            if (signed'(mat[8]) > signed'(mat[4]))
                pick_w = BR_Z;
        end else begin
            if (signed'(mat[8]) > signed'(mat[0]))
                pick_w = BR_Z;
        end
        br_w = (tr_w > 22'sd0) ? BR_TRACE : pick_w;
    end

    side_t                    side1_reg;
    logic [8:0][FIELD_W-1:0]  m1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg.valid <= 1'b0;
        end else if (adv) begin
            side1_reg.valid  <= in_valid;
            side1_reg.degen  <= |row_small;
            side1_reg.branch <= br_w;
            m1_reg           <= mat;
        end
    end

    // ---- stage 2 ----
    logic signed [EW-1:0] e [9];
    logic signed [20:0]   d_w [4];
    logic [3:0]           root_w;
    logic signed [EW-1:0] t_w;

    always_comb begin
        for (int n = 0; n < 9; n++)
            e[n] = EW'(signed'(m1_reg[n]));
    end

    always_comb begin
        for (int p = 0; p < 4; p++)
            d_w[p] = '0;
        root_w = '0;
        unique case (side1_reg.branch)
            BR_TRACE: begin
                root_w[P_W] = 1'b1;
                t_w    = e[0] + e[4] + e[8] + ONE;
                d_w[P_X] = 21'(e[5] - e[7]);
                d_w[P_Y] = 21'(e[6] - e[2]);
                d_w[P_Z] = 21'(e[1] - e[3]);
            end
            BR_X: begin
                root_w[P_X] = 1'b1;
                t_w    = e[0] - e[4] - e[8] + ONE;
                d_w[P_W] = 21'(e[5] - e[7]);
                d_w[P_Y] = 21'(e[1] + e[3]);
                d_w[P_Z] = 21'(e[2] + e[6]);
            end
            BR_Y: begin
                root_w[P_Y] = 1'b1;
                t_w    = e[4] - e[8] - e[0] + ONE;
                d_w[P_W] = 21'(e[6] - e[2]);
                d_w[P_Z] = 21'(e[5] + e[7]);
                d_w[P_X] = 21'(e[3] + e[1]);
            end
            BR_Z: begin
                root_w[P_Z] = 1'b1;
                t_w    = e[8] - e[0] - e[4] + ONE;
                d_w[P_W] = 21'(e[1] - e[3]);
                d_w[P_X] = 21'(e[6] + e[2]);
                d_w[P_Y] = 21'(e[7] + e[5]);
            end
            default: begin
                t_w = ONE;
            end
        endcase
    end

    side_t              side2_reg;
    logic signed [20:0] d2_reg [4];
    logic [3:0]         root2_reg;
    logic [TW-1:0]      t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side2_reg.valid <= 1'b0;
        end else if (adv) begin
            side2_reg <= side1_reg;
            d2_reg    <= d_w;
            root2_reg <= root_w;
            t2_reg    <= t_w[TW-1:0];
        end
    end

    // ---- stage 3: square the numerators ----
    side_t                  side3_reg;
    logic [3:0][SQ_W-1:0]   sq3_reg;
    logic [3:0][TW-1:0]     div3_reg;
    logic [3:0]             neg3_reg;

    always_ff @(posedge aclk) begin
        logic [20:0] mg;
        logic [41:0] prod;
        if (!aresetn) begin
            side3_reg.valid <= 1'b0;
        end else if (adv) begin
            side3_reg <= side2_reg;
            for (int p = 0; p < 4; p++) begin
                mg   = d2_reg[p][20] ? 21'(-d2_reg[p]) : 21'(d2_reg[p]);
                prod = {21'd0, mg} * {21'd0, mg};
                if (root2_reg[p]) begin
                    sq3_reg[p]  <= {{(SQ_W-TW){1'b0}}, t2_reg};
                    div3_reg[p] <= TW'(1);
                    neg3_reg[p] <= 1'b0;
                end else begin
                    sq3_reg[p]  <= prod[SQ_W-1:0];
                    div3_reg[p] <= t2_reg;
                    neg3_reg[p] <= d2_reg[p][20];
                end
            end
        end
    end

    assign side_out = side3_reg;
    assign sq_out   = sq3_reg;
    assign div_out  = div3_reg;
    assign neg_out  = neg3_reg;

endmodule

@@ sv/mq_lane.sv @@
// One component lane: pipelined restoring divide, then pipelined integer root.
module mq_lane #(
    parameter int FRAC_BITS = mq_pkg::FRAC_BITS_DEF,
    parameter int TW        = mq_pkg::tw_of(mq_pkg::FRAC_BITS_DEF)
) (
    input  logic                        aclk,
    input  logic                        adv,
    input  logic [mq_pkg::SQ_W-1:0]     sq_in,
    input  logic [TW-1:0]               div_in,
    input  logic                        neg_in,
    output logic [mq_pkg::FIELD_W-1:0]  q_out
);
    import mq_pkg::*;

    localparam int XW = SQ_W + FRAC_BITS;
    localparam int HW = XW - QW;

    // ---- setup: scale, overflow test, first partial remainder ----
    logic [XW-1:0] x_w;
    logic [HW-1:0] hi_w;
    logic [TW-1:0] hi_ext;

    assign x_w    = {{FRAC_BITS{1'b0}}, sq_in} << FRAC_BITS;
    assign hi_w   = x_w[XW-1:QW];
    assign hi_ext = {{(TW-HW){1'b0}}, hi_w};

    logic [TW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic [TW-1:0] div_reg [0:QW];
    logic          ovf_reg [0:QW];
    logic          neg_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= hi_ext;
            low_reg[0] <= x_w[QW-1:0];
            quo_reg[0] <= '0;
            div_reg[0] <= div_in;
            ovf_reg[0] <= (hi_ext >= div_in);
            neg_reg[0] <= neg_in;
        end
    end

    // ---- one quotient bit per stage ----
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [TW:0]   r2;
        logic [TW:0]   diff;
        logic          ge;

        assign r2   = {rem_reg[k], low_reg[k][QW-1]};
        assign ge   = (r2 >= {1'b0, div_reg[k]});
        assign diff = r2 - {1'b0, div_reg[k]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k+1] <= ge ? diff[TW-1:0] : r2[TW-1:0];
                low_reg[k+1] <= {low_reg[k][QW-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][QW-2:0], ge};
                div_reg[k+1] <= div_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // ---- one root bit per stage ----
    logic [20:0]   srem_reg [1:ROOT_STEPS];
    logic [19:0]   root_reg [1:ROOT_STEPS];
    logic [QW-1:0] qs_reg   [1:ROOT_STEPS];
    logic          rovf_reg [1:ROOT_STEPS];
    logic          rneg_reg [1:ROOT_STEPS];

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        logic [20:0]   srem_i;
        logic [19:0]   root_i;
        logic [QW-1:0] qs_i;
        logic          ovf_i;
        logic          neg_i;
        logic [22:0]   r2;
        logic [22:0]   trial;
        logic [22:0]   diff;
        logic          ge;

        if (j == 0) begin : g_first
            assign srem_i = '0;
            assign root_i = '0;
            assign qs_i   = quo_reg[QW];
            assign ovf_i  = ovf_reg[QW];
            assign neg_i  = neg_reg[QW];
        end else begin : g_next
            assign srem_i = srem_reg[j];
            assign root_i = root_reg[j];
            assign qs_i   = qs_reg[j];
            assign ovf_i  = rovf_reg[j];
            assign neg_i  = rneg_reg[j];
        end

        assign r2    = {srem_i, qs_i[QW-1:QW-2]};
        assign trial = {1'b0, root_i, 2'b01};
        assign ge    = (r2 >= trial);
        assign diff  = r2 - trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                srem_reg[j+1] <= ge ? diff[20:0] : r2[20:0];
                root_reg[j+1] <= {root_i[18:0], ge};
                qs_reg[j+1]   <= {qs_i[QW-3:0], 2'b00};
                rovf_reg[j+1] <= ovf_i;
                rneg_reg[j+1] <= neg_i;
            end
        end
    end

    // ---- root plus one, halved (half the root, rounded to nearest); then encode ----
    logic [20:0]        rsum;
    logic [FIELD_W-1:0] n_w;
    logic [FIELD_W-1:0] q_next;

    assign rsum = {1'b0, root_reg[ROOT_STEPS]} + 21'd1;
    assign n_w  = rovf_reg[ROOT_STEPS] ? NEG_MIN : rsum[20:1];

    always_comb begin
        if (rneg_reg[ROOT_STEPS])
            q_next = FIELD_W'(20'd0 - n_w);
        else if (n_w > POS_MAX)
            q_next = POS_MAX;
        else
            q_next = n_w;
    end

    logic [FIELD_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (adv)
            q_reg <= q_next;
    end

    assign q_out = q_reg;

endmodule

@@ sv/matrix_to_quaternion_unit.sv @@
// Top level of the rotation matrix to quaternion pipeline.
//
// Takes one 3x3 matrix per cycle and returns one quaternion per matrix
// through three front stages (zero-row test and branch pick, operand
// forming, squaring) and 62 stages in each of four component lanes
// (setup, a 40-step restoring divider, a 20-step integer square root,
// encode). Every stage holds one item, so the sustained rate is one
// matrix per cycle; a stall on the result side freezes the whole
// pipeline, and s_ready follows m_ready whenever a result is waiting.
// zero_tolerance resets to 7 and is written through cfg_wr_en/cfg_wr_data.
module matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = mq_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mq_pkg::TOL_W-1:0]           cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m00,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m01,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m02,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m10,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m11,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m12,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m20,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m21,
    input  logic signed [mq_pkg::FIELD_W-1:0]  s_m22,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mq_pkg::FIELD_W-1:0]  m_quat_x,
    output logic signed [mq_pkg::FIELD_W-1:0]  m_quat_y,
    output logic signed [mq_pkg::FIELD_W-1:0]  m_quat_z,
    output logic signed [mq_pkg::FIELD_W-1:0]  m_quat_w,
    output logic                               m_degenerate,
    output logic [1:0]                         m_branch_used
);
    import mq_pkg::*;

    localparam int TW = tw_of(FRAC_BITS);
    localparam logic [FIELD_W-1:0] W_ONE =
        (FRAC_BITS >= FIELD_W - 1) ? POS_MAX : FIELD_W'(1 << FRAC_BITS);

    logic [TOL_W-1:0]    zero_tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            zero_tol_reg <= TOL_RESET;
        else if (cfg_wr_en)
            zero_tol_reg <= cfg_wr_data;
    end

    side_t                 side_reg [0:LANE_LAT-1];
    logic                  adv;
    logic [8:0][FIELD_W-1:0] mat;
    side_t                 front_side;
    logic [3:0][SQ_W-1:0]  sq_w;
    logic [3:0][TW-1:0]    div_w;
    logic [3:0]            neg_w;
    logic [3:0][FIELD_W-1:0] q_w;

    // Advance everything unless a finished result is held.
    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;

    assign mat = {s_m22, s_m21, s_m20, s_m12, s_m11, s_m10, s_m02, s_m01, s_m00};

    mq_front #(
        .FRAC_BITS (FRAC_BITS),
        .TW        (TW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .mat      (mat),
        .tol      (zero_tol_reg),
        .side_out (front_side),
        .sq_out   (sq_w),
        .div_out  (div_w),
        .neg_out  (neg_w)
    );

    for (genvar p = 0; p < 4; p++) begin : g_lane
        mq_lane #(
            .FRAC_BITS (FRAC_BITS),
            .TW        (TW)
        ) u_lane (
            .aclk   (aclk),
            .adv    (adv),
            .sq_in  (sq_w[p]),
            .div_in (div_w[p]),
            .neg_in (neg_w[p]),
            .q_out  (q_w[p])
        );
    end

    // Sideband travels alongside the lanes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < LANE_LAT; s++)
                side_reg[s].valid <= 1'b0;
        end else if (adv) begin
            side_reg[0] <= front_side;
            for (int s = 1; s < LANE_LAT; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    side_t last_side;
    assign last_side = side_reg[LANE_LAT-1];

    assign m_valid       = last_side.valid;
    assign m_degenerate  = last_side.degen;
    assign m_branch_used = last_side.degen ? BR_TRACE : last_side.branch;
    assign m_quat_x      = last_side.degen ? '0 : q_w[P_X];
    assign m_quat_y      = last_side.degen ? '0 : q_w[P_Y];
    assign m_quat_z      = last_side.degen ? '0 : q_w[P_Z];
    assign m_quat_w      = last_side.degen ? W_ONE : q_w[P_W];

endmodule

@@ sv/mq_checker.sv @@
// Port-level checks for the matrix to quaternion pipeline, bound to the top.
`include "assert_macros.svh"

module mq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [mq_pkg::FIELD_W-1:0]  m_quat_x,
    input logic signed [mq_pkg::FIELD_W-1:0]  m_quat_y,
    input logic signed [mq_pkg::FIELD_W-1:0]  m_quat_z,
    input logic signed [mq_pkg::FIELD_W-1:0]  m_quat_w,
    input logic                               m_degenerate,
    input logic [1:0]                         m_branch_used
);
    import mq_pkg::*;

    // A held result keeps its payload.
    `MQ_ASSERT_CLK(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_quat_x) && $stable(m_quat_y) && $stable(m_quat_z) && $stable(m_quat_w) && $stable(m_branch_used), "result changed while stalled")

    // Input side stalls only while a result waits.
    `MQ_ASSERT_CLK(a_ready, aclk, aresetn, s_ready == (m_ready || !m_valid), "s_ready does not track the output stage")

    // A near-zero row gives zero x, y and z and reports the trace branch.
    `MQ_ASSERT_CLK(a_degen, aclk, aresetn, m_valid && m_degenerate |-> m_quat_x == 0 && m_quat_y == 0 && m_quat_z == 0 && m_branch_used == BR_TRACE, "degenerate result is not the identity")

    // Nothing comes out right after reset.
    `MQ_ASSERT_RAW(a_reset, aclk, !aresetn |=> !m_valid, "result valid after reset")

    logic unused_in;
    assign unused_in = s_valid;

endmodule

bind matrix_to_quaternion_unit mq_checker u_mq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_quat_x      (m_quat_x),
    .m_quat_y      (m_quat_y),
    .m_quat_z      (m_quat_z),
    .m_quat_w      (m_quat_w),
    .m_degenerate  (m_degenerate),
    .m_branch_used (m_branch_used)
);
